/* sv/text_encoding_transcoder_top_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the transcoder
// Shared concurrent assertion forms.
// ----------------------------------------------------------------------------
`ifndef TEXT_ENCODING_TRANSCODER_TOP_MACROS_SVH
`define TEXT_ENCODING_TRANSCODER_TOP_MACROS_SVH

// implication checked every cycle out of reset
`define TET_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define TET_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* sv/tet_pkg.sv */
// ----------------------------------------------------------------------------
// tet_pkg
// Encoding codes, status codes and the transaction record passed front to back.
// ----------------------------------------------------------------------------
package tet_pkg;

    localparam logic [2:0] ENC_LATIN1  = 3'd0;
    localparam logic [2:0] ENC_ASCII   = 3'd1;
    localparam logic [2:0] ENC_UTF8    = 3'd2;
    localparam logic [2:0] ENC_UTF16LE = 3'd3;
    localparam logic [2:0] ENC_UTF16BE = 3'd4;
    localparam logic [2:0] ENC_HEX     = 3'd5;
    localparam logic [2:0] ENC_BASE64  = 3'd6;

    localparam logic [3:0] ST_OK        = 4'd0;
    localparam logic [3:0] ST_NOT_ASCII = 4'd1;
    localparam logic [3:0] ST_BAD_UTF8  = 4'd2;
    localparam logic [3:0] ST_SHORT_U8  = 4'd3;
    localparam logic [3:0] ST_OVERLONG  = 4'd4;
    localparam logic [3:0] ST_ABOVE_MAX = 4'd5;
    localparam logic [3:0] ST_SHORT_U16 = 4'd6;
    localparam logic [3:0] ST_BAD_SURR  = 4'd7;
    localparam logic [3:0] ST_BAD_HEX   = 4'd8;
    localparam logic [3:0] ST_BAD_B64   = 4'd9;
    localparam logic [3:0] ST_TOO_WIDE  = 4'd10;
    localparam logic [3:0] ST_TRUNC     = 4'd11;

    localparam int QDEPTH = 4;
    localparam int QAW    = 2;

    // one entry: up to four bytes, count, end marker, status
    typedef struct packed {
        logic [31:0] bytes;   // byte k at [8k+7:8k]
        logic [2:0]  n;       // 0..4 bytes; 0 with emit means bare marker
        logic        emit;    // produces at least one result
        logic        last;
        logic [3:0]  status;
    } tet_job_t;

    function automatic logic [2:0] eff_enc(input logic [2:0] e);
        return (e == 3'd7) ? ENC_LATIN1 : e;
    endfunction

    function automatic logic [7:0] b64_char(input logic [5:0] v);
        logic [7:0] r;
        if (v < 6'd26)      r = 8'h41 + {2'b0, v};
        else if (v < 6'd52) r = 8'h61 + {2'b0, v} - 8'd26;
        else if (v < 6'd62) r = 8'h30 + {2'b0, v} - 8'd52;
        else if (v == 6'd62) r = 8'h2B;
        else                r = 8'h2F;
        return r;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        return (v < 4'd10) ? (8'h30 + {4'b0, v}) : (8'h37 + {4'b0, v});
    endfunction

endpackage

/* sv/tet_front.sv */
// ----------------------------------------------------------------------------
// tet_front
// Decodes one source byte per transaction, re-encodes it and forms a job.
// ----------------------------------------------------------------------------
module tet_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [2:0]        cfg_data,
    input  logic              step,
    input  logic [7:0]        in_byte,
    input  logic              in_last,
    output tet_pkg::tet_job_t job
);

    logic [2:0]  src_reg, dst_reg;
    logic [20:0] dacc_reg, dacc_next;
    logic [2:0]  dcnt_reg, dcnt_next;
    logic [1:0]  dcls_reg, dcls_next;
    logic [15:0] pend_reg, pend_next;
    logic        b64e_reg, b64e_next;
    logic [15:0] eacc_reg, eacc_next;
    logic [1:0]  ecnt_reg, ecnt_next;
    logic        fail_reg, fail_next;

    logic [2:0]  se, de;
    logic [3:0]  st;
    logic        have;
    logic [20:0] cp;
    logic [31:0] buf_w;
    logic [2:0]  n;
    logic [4:0]  hv;
    logic [6:0]  bv;
    logic [15:0] unit;
    logic [20:0] acc6, a16;
    logic [20:0] minv;
    logic [23:0] q;

    always_comb
    begin
        se = tet_pkg::eff_enc(src_reg);
        de = tet_pkg::eff_enc(dst_reg);
        dacc_next = dacc_reg; dcnt_next = dcnt_reg; dcls_next = dcls_reg;
        pend_next = pend_reg; b64e_next = b64e_reg; eacc_next = eacc_reg;
        ecnt_next = ecnt_reg; fail_next = fail_reg;
        st = tet_pkg::ST_OK; have = 1'b0; cp = '0; buf_w = '0; n = 3'd0;
        unit = '0; acc6 = '0; minv = '0; a16 = '0; q = '0;
        job = '0;

        if (in_byte >= 8'h30 && in_byte <= 8'h39)      hv = {1'b0, in_byte[3:0]};
        else if (in_byte >= 8'h41 && in_byte <= 8'h46) hv = {1'b0, in_byte[3:0] + 4'd9};
        else if (in_byte >= 8'h61 && in_byte <= 8'h66) hv = {1'b0, in_byte[3:0] + 4'd9};
        else hv = 5'h10;

        if (in_byte >= 8'h41 && in_byte <= 8'h5A)      bv = {1'b0, in_byte[5:0] - 6'd1};
        else if (in_byte >= 8'h61 && in_byte <= 8'h7A) bv = {1'b0, in_byte[5:0] - 6'd7};
        else if (in_byte >= 8'h30 && in_byte <= 8'h39) bv = {1'b0, in_byte[5:0] + 6'd4};
        else if (in_byte == 8'h2B) bv = 7'd62;
        else if (in_byte == 8'h2F) bv = 7'd63;
        else bv = 7'h40;

        case (se)
            tet_pkg::ENC_ASCII:
            begin
                if (in_byte[7]) st = tet_pkg::ST_NOT_ASCII;
                else begin cp = {13'b0, in_byte}; have = 1'b1; end
            end
            tet_pkg::ENC_UTF8:
            begin
                if (dcnt_reg == 3'd0)
                begin
                    if (!in_byte[7]) begin cp = {13'b0, in_byte}; have = 1'b1; end
                    else if (in_byte[6:5] == 2'b10)
                    begin
                        dcls_next = 2'd1; dacc_next = {16'b0, in_byte[4:0]}; dcnt_next = 3'd1;
                        if (in_last) st = tet_pkg::ST_SHORT_U8;
                    end
                    else if (in_byte[6:4] == 3'b110)
                    begin
                        dcls_next = 2'd2; dacc_next = {17'b0, in_byte[3:0]}; dcnt_next = 3'd2;
                        if (in_last) st = tet_pkg::ST_SHORT_U8;
                    end
                    else if (in_byte[6:3] == 4'b1110)
                    begin
                        dcls_next = 2'd3; dacc_next = {18'b0, in_byte[2:0]}; dcnt_next = 3'd3;
                        if (in_last) st = tet_pkg::ST_SHORT_U8;
                    end
                    else st = tet_pkg::ST_BAD_UTF8;
                end
                else if (in_last && dcnt_reg > 3'd1) st = tet_pkg::ST_SHORT_U8;
                else if (in_byte[7:6] != 2'b10) st = tet_pkg::ST_BAD_UTF8;
                else
                begin
                    acc6 = {dacc_reg[14:0], in_byte[5:0]};
                    dacc_next = acc6;
                    dcnt_next = dcnt_reg - 3'd1;
                    if (dcnt_reg == 3'd1)
                    begin
                        minv = (dcls_reg == 2'd1) ? 21'h80 :
                               (dcls_reg == 2'd2) ? 21'h800 : 21'h10000;
                        dcls_next = 2'd0; dacc_next = '0;
                        if (acc6 < minv) st = tet_pkg::ST_OVERLONG;
                        else if (acc6 > 21'h10FFFF) st = tet_pkg::ST_ABOVE_MAX;
                        else begin cp = acc6; have = 1'b1; end
                    end
                end
            end
            tet_pkg::ENC_UTF16LE, tet_pkg::ENC_UTF16BE:
            begin
                if (dcnt_reg == 3'd0)
                begin
                    dacc_next = {13'b0, in_byte}; dcnt_next = 3'd1;
                end
                else
                begin
                    unit = (se == tet_pkg::ENC_UTF16LE) ? {in_byte, dacc_reg[7:0]}
                                                        : {dacc_reg[7:0], in_byte};
                    dcnt_next = 3'd0; dacc_next = '0;
                    if (dcls_reg != 2'd0)
                    begin
                        if (unit[15:10] != 6'b110111) st = tet_pkg::ST_BAD_SURR;
                        else
                        begin
                            cp = 21'h10000 + {1'b0, pend_reg[9:0], unit[9:0]};
                            dcls_next = 2'd0; pend_next = '0; have = 1'b1;
                        end
                    end
                    else if (unit[15:10] == 6'b110110)
                    begin
                        pend_next = unit; dcls_next = 2'd1;
                    end
                    else if (unit[15:10] == 6'b110111) st = tet_pkg::ST_BAD_SURR;
                    else begin cp = {5'b0, unit}; have = 1'b1; end
                end
            end
            tet_pkg::ENC_HEX:
            begin
                if (dcnt_reg == 3'd0)
                begin
                    if (in_byte == 8'h20 || (in_byte >= 8'h09 && in_byte <= 8'h0D)) ;
                    else if (hv[4]) st = tet_pkg::ST_BAD_HEX;
                    else begin dacc_next = {17'b0, hv[3:0]}; dcnt_next = 3'd1; end
                end
                else if (hv[4]) st = tet_pkg::ST_BAD_HEX;
                else
                begin
                    cp = {13'b0, dacc_reg[3:0], hv[3:0]}; have = 1'b1;
                    dacc_next = '0; dcnt_next = 3'd0;
                end
            end
            tet_pkg::ENC_BASE64:
            begin
                if (b64e_reg || in_byte <= 8'h20) ;
                else if (in_byte == 8'h3D)
                begin
                    if (dcnt_reg < 3'd2) st = tet_pkg::ST_BAD_B64;
                    else begin b64e_next = 1'b1; dcnt_next = 3'd0; dacc_next = '0; end
                end
                else if (bv[6]) st = tet_pkg::ST_BAD_B64;
                else
                begin
                    case (dcnt_reg)
                        3'd0:
                        begin
                            dacc_next = {15'b0, bv[5:0]}; dcnt_next = 3'd1;
                        end
                        3'd1:
                        begin
                            cp = {13'b0, dacc_reg[5:0], bv[5:4]}; have = 1'b1;
                            dacc_next = {17'b0, bv[3:0]}; dcnt_next = 3'd2;
                        end
                        3'd2:
                        begin
                            cp = {13'b0, dacc_reg[3:0], bv[5:2]}; have = 1'b1;
                            dacc_next = {19'b0, bv[1:0]}; dcnt_next = 3'd3;
                        end
                        default:
                        begin
                            cp = {13'b0, dacc_reg[1:0], bv[5:0]}; have = 1'b1;
                            dacc_next = '0; dcnt_next = 3'd0;
                        end
                    endcase
                end
            end
            default:
            begin
                cp = {13'b0, in_byte}; have = 1'b1;
            end
        endcase

        if (st == tet_pkg::ST_OK && have)
        begin
            if (cp >= 21'h110000) st = tet_pkg::ST_TOO_WIDE;
            else
            begin
                case (de)
                    tet_pkg::ENC_ASCII:
                    begin
                        if (cp >= 21'h80) st = tet_pkg::ST_TOO_WIDE;
                        else begin buf_w[7:0] = cp[7:0]; n = 3'd1; end
                    end
                    tet_pkg::ENC_UTF8:
                    begin
                        if (cp < 21'h80) begin buf_w[7:0] = cp[7:0]; n = 3'd1; end
                        else if (cp < 21'h800)
                        begin
                            buf_w[15:0] = {2'b10, cp[5:0], 3'b110, cp[10:6]}; n = 3'd2;
                        end
                        else if (cp < 21'h10000)
                        begin
                            buf_w[23:0] = {2'b10, cp[5:0], 2'b10, cp[11:6], 4'b1110, cp[15:12]};
                            n = 3'd3;
                        end
                        else
                        begin
                            buf_w = {2'b10, cp[5:0], 2'b10, cp[11:6], 2'b10, cp[17:12],
                                     5'b11110, cp[20:18]};
                            n = 3'd4;
                        end
                    end
                    tet_pkg::ENC_UTF16LE, tet_pkg::ENC_UTF16BE:
                    begin
                        if (cp >= 21'hD800 && cp < 21'hE000) st = tet_pkg::ST_TOO_WIDE;
                        else if (cp < 21'h10000)
                        begin
                            buf_w[15:0] = (de == tet_pkg::ENC_UTF16LE) ? {cp[15:8], cp[7:0]}
                                                                       : {cp[7:0], cp[15:8]};
                            n = 3'd2;
                        end
                        else
                        begin
                            a16 = cp - 21'h10000;
                            buf_w = (de == tet_pkg::ENC_UTF16LE)
                                ? {6'b110111, a16[9:8], a16[7:0], 6'b110110, a16[19:18], a16[17:10]}
                                : {a16[7:0], 6'b110111, a16[9:8], a16[17:10], 6'b110110, a16[19:18]};
                            n = 3'd4;
                        end
                    end
                    tet_pkg::ENC_HEX:
                    begin
                        if (cp >= 21'h100) st = tet_pkg::ST_TOO_WIDE;
                        else
                        begin
                            buf_w[15:0] = {tet_pkg::hex_char(cp[3:0]), tet_pkg::hex_char(cp[7:4])};
                            n = 3'd2;
                        end
                    end
                    tet_pkg::ENC_BASE64:
                    begin
                        if (cp >= 21'h100) st = tet_pkg::ST_TOO_WIDE;
                        else if (ecnt_reg == 2'd2)
                        begin
                            q = {eacc_reg, cp[7:0]};
                            buf_w = {tet_pkg::b64_char(q[5:0]), tet_pkg::b64_char(q[11:6]),
                                     tet_pkg::b64_char(q[17:12]), tet_pkg::b64_char(q[23:18])};
                            n = 3'd4; eacc_next = '0; ecnt_next = 2'd0;
                        end
                        else
                        begin
                            eacc_next = {eacc_reg[7:0], cp[7:0]}; ecnt_next = ecnt_reg + 2'd1;
                        end
                    end
                    default:
                    begin
                        if (cp >= 21'h100) st = tet_pkg::ST_TOO_WIDE;
                        else begin buf_w[7:0] = cp[7:0]; n = 3'd1; end
                    end
                endcase
            end
        end

        if (st == tet_pkg::ST_OK && in_last)
        begin
            if (se == tet_pkg::ENC_UTF8 && dcnt_next != 3'd0) st = tet_pkg::ST_SHORT_U8;
            else if ((se == tet_pkg::ENC_UTF16LE || se == tet_pkg::ENC_UTF16BE)
                     && dcls_next != 2'd0) st = tet_pkg::ST_SHORT_U16;
            else if ((se == tet_pkg::ENC_UTF16LE || se == tet_pkg::ENC_UTF16BE
                      || se == tet_pkg::ENC_HEX) && dcnt_next != 3'd0) st = tet_pkg::ST_TRUNC;
            else if (se == tet_pkg::ENC_BASE64 && !b64e_next && dcnt_next != 3'd0)
                st = tet_pkg::ST_TRUNC;
        end

        if (st == tet_pkg::ST_OK && in_last && de == tet_pkg::ENC_BASE64
            && ecnt_next != 2'd0 && n == 3'd0)
        begin
            if (ecnt_next == 2'd1)
            begin
                q = {eacc_next[7:0], 16'b0};
                buf_w = {8'h3D, 8'h3D, tet_pkg::b64_char(q[17:12]), tet_pkg::b64_char(q[23:18])};
            end
            else
            begin
                q = {eacc_next, 8'b0};
                buf_w = {8'h3D, tet_pkg::b64_char(q[11:6]), tet_pkg::b64_char(q[17:12]),
                         tet_pkg::b64_char(q[23:18])};
            end
            n = 3'd4;
        end

        job.bytes  = buf_w;
        job.last   = in_last;
        job.status = st;
        if (fail_reg)
        begin
            job.emit = 1'b0;
            if (in_last) fail_next = 1'b0;
        end
        else if (st != tet_pkg::ST_OK)
        begin
            job.emit = 1'b1; job.n = 3'd0; job.last = 1'b1; job.bytes = '0;
            if (!in_last) fail_next = 1'b1;
        end
        else
        begin
            job.n = n;
            job.emit = in_last || (n != 3'd0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_reg <= '0; dst_reg <= '0;
            dacc_reg <= '0; dcnt_reg <= '0; dcls_reg <= '0; pend_reg <= '0;
            b64e_reg <= 1'b0; eacc_reg <= '0; ecnt_reg <= '0; fail_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            if (cfg_index) dst_reg <= cfg_data;
            else src_reg <= cfg_data;
            dacc_reg <= '0; dcnt_reg <= '0; dcls_reg <= '0; pend_reg <= '0;
            b64e_reg <= 1'b0; eacc_reg <= '0; ecnt_reg <= '0; fail_reg <= 1'b0;
        end
        else if (step)
        begin
            if (in_last || fail_reg || job.status != tet_pkg::ST_OK)
            begin
                dacc_reg <= '0; dcnt_reg <= '0; dcls_reg <= '0; pend_reg <= '0;
                b64e_reg <= 1'b0; eacc_reg <= '0; ecnt_reg <= '0;
                fail_reg <= fail_next;
            end
            else
            begin
                dacc_reg <= dacc_next; dcnt_reg <= dcnt_next; dcls_reg <= dcls_next;
                pend_reg <= pend_next; b64e_reg <= b64e_next; eacc_reg <= eacc_next;
                ecnt_reg <= ecnt_next; fail_reg <= fail_next;
            end
        end
    end

endmodule

/* sv/tet_back.sv */
// ----------------------------------------------------------------------------
// tet_back
// Job queue and serializer: sends each job's bytes one transaction per cycle while out_ready is high.
// ----------------------------------------------------------------------------
module tet_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  tet_pkg::tet_job_t job,
    output logic              full,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [7:0]        out_byte,
    output logic              has_byte,
    output logic              out_last,
    output logic [3:0]        status
);

    tet_pkg::tet_job_t mem_reg [tet_pkg::QDEPTH];
    logic [tet_pkg::QAW-1:0] wp_reg, rp_reg;
    logic [tet_pkg::QAW:0]   cnt_reg;
    logic [1:0]              idx_reg;
    tet_pkg::tet_job_t       head;
    logic                    pop, fin;

    assign head      = mem_reg[rp_reg];
    assign full      = (cnt_reg == tet_pkg::QAW'(0) + (tet_pkg::QAW+1)'(tet_pkg::QDEPTH));
    assign out_valid = (cnt_reg != '0);
    assign has_byte  = (head.n != 3'd0);
    assign out_byte  = has_byte ? head.bytes[{idx_reg, 3'b000} +: 8] : 8'h00;
    assign fin       = (head.n == 3'd0) || ({1'b0, idx_reg} == head.n - 3'd1);
    assign out_last  = head.last && fin;
    assign status    = head.status;
    assign pop       = out_valid && out_ready && fin;

    always_ff @(posedge clk)
    begin
        if (push) mem_reg[wp_reg] <= job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0; rp_reg <= '0; cnt_reg <= '0; idx_reg <= '0;
        end
        else
        begin
            if (push) wp_reg <= wp_reg + 1'b1;
            if (pop) rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + {2'b0, push} - {2'b0, pop};
            if (out_valid && out_ready) idx_reg <= fin ? 2'd0 : idx_reg + 2'd1;
        end
    end

    `include "text_encoding_transcoder_top_macros.svh"

    `TET_ASSERT_IMP(a_no_overflow, push, !full || pop)
    `TET_ASSERT_IMP(a_cnt_range, 1'b1, cnt_reg <= 3'(tet_pkg::QDEPTH))
    `TET_ASSERT_IMP(a_marker_last, out_valid && !has_byte, out_last)
    `TET_ASSERT_NEXT(a_idx_reset, pop, idx_reg == 2'd0)

endmodule

/* sv/text_encoding_transcoder_top.sv */
// ----------------------------------------------------------------------------
// text_encoding_transcoder_top
// Streaming transcoder between latin1, ascii, utf8, utf16le/be, hex and base64.
// ----------------------------------------------------------------------------
// Each accepted byte is decoded and re-encoded combinationally and queued as a
// job of up to four result bytes; the serializer sends one result transaction
// per cycle while out_ready is high. The four-entry job queue lets input
// continue while results drain; output rate bounds sustained throughput.
module text_encoding_transcoder_top
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [2:0] cfg_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       has_byte,
    output logic       out_last,
    output logic [3:0] status
);

    tet_pkg::tet_job_t job;
    logic full, step;

    assign in_ready = !full;
    assign step     = in_valid && in_ready;

    tet_front u_front
    (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .step(step), .in_byte(in_byte), .in_last(in_last),
        .job(job)
    );

    tet_back u_back
    (
        .clk(clk), .rst_n(rst_n), .push(step && job.emit), .job(job), .full(full),
        .out_valid(out_valid), .out_ready(out_ready), .out_byte(out_byte),
        .has_byte(has_byte), .out_last(out_last), .status(status)
    );

endmodule

/* verif/text_encoding_transcoder_top_tb.sv */
// ----------------------------------------------------------------------------
// text_encoding_transcoder_top_tb
// Self-checking bench: each accepted source byte is run through an in-bench
// transcoder that tracks decode and encode state. Every returned transaction
// is checked against the oldest predicted one. Directed error streams come
// first, then random well-formed streams with noise. The phases vary the
// encoding pairs and the idle and stall patterns on both channels.
// ----------------------------------------------------------------------------
module text_encoding_transcoder_top_tb;
    import tet_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] b;
        logic       l;
    } src_item_t;

    typedef struct packed {
        logic [7:0] b;
        logic       h;
        logic       l;
        logic [3:0] s;
    } xfer_t;

    localparam int WATCHDOG = 5000;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_we = 1'b0;
    logic       cfg_index = 1'b0;
    logic [2:0] cfg_data = 3'd0;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] in_byte;
    logic       in_last;
    logic       out_valid;
    logic       out_ready;
    logic [7:0] out_byte;
    logic       has_byte;
    logic       out_last;
    logic [3:0] status;

    src_item_t  pending_bytes[$];
    src_item_t  stream_buf[$];
    xfer_t      expected_xfers[$];
    int         errors = 0;
    int         send_idle_pct = 0;
    int         recv_stall_pct = 0;
    int         quiet_cycles = 0;

    // transcoder state
    logic [2:0]  src_enc, dst_enc;
    logic [20:0] dacc;
    logic [2:0]  dcnt;
    logic [1:0]  dcls;
    logic [15:0] held_unit;
    logic        b64_done;
    logic [15:0] eacc;
    logic [1:0]  ecnt;
    logic        stream_failed;
    logic [7:0]  ob[4];

    string hex_chars = "0123456789ABCDEF";
    string b64_chars = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    text_encoding_transcoder_top uut (.*);

    always #5 clk = ~clk;

    function automatic logic [2:0] norm_enc(input logic [2:0] e);
        return (e == 3'd7) ? ENC_LATIN1 : e;
    endfunction

    function automatic void clear_stream();
        dacc = '0; dcnt = '0; dcls = '0; held_unit = '0;
        b64_done = 1'b0; eacc = '0; ecnt = '0; stream_failed = 1'b0;
    endfunction

    function automatic int hex_val(input int b);
        if (b >= "0" && b <= "9") return b - "0";
        if (b >= "A" && b <= "F") return b - "A" + 10;
        if (b >= "a" && b <= "f") return b - "a" + 10;
        return -1;
    endfunction

    function automatic int sextet_val(input int b);
        if (b >= "A" && b <= "Z") return b - "A";
        if (b >= "a" && b <= "z") return b - "a" + 26;
        if (b >= "0" && b <= "9") return b - "0" + 52;
        if (b == "+") return 62;
        if (b == "/") return 63;
        return -1;
    endfunction

    function automatic logic [3:0] decode_in(input int b, input bit lst,
                                             output int cp, output bit have);
        logic [2:0] e;
        int v, sel, unit, minv, acc;
        e = norm_enc(src_enc);
        have = 0;
        cp = 0;
        case (e)
            ENC_LATIN1:
            begin
                cp = b; have = 1; return ST_OK;
            end
            ENC_ASCII:
            begin
                if (b >= 'h80) return ST_NOT_ASCII;
                cp = b; have = 1; return ST_OK;
            end
            ENC_UTF8:
            begin
                if (dcnt == 0) begin
                    if (b < 'h80) begin cp = b; have = 1; return ST_OK; end
                    sel = (b >> 3) & 'hF;
                    if (sel >= 8 && sel <= 11) begin dcls = 1; dacc = b & 'h1F; end
                    else if (sel == 12 || sel == 13) begin dcls = 2; dacc = b & 'h0F; end
                    else if (sel == 14) begin dcls = 3; dacc = b & 'h07; end
                    else return ST_BAD_UTF8;
                    dcnt = dcls;
                    return lst ? ST_SHORT_U8 : ST_OK;
                end
                if (lst && dcnt > 1) return ST_SHORT_U8;
                if ((b & 'hC0) != 'h80) return ST_BAD_UTF8;
                dacc = (dacc << 6) | 21'(b & 'h3F);
                dcnt = dcnt - 1;
                if (dcnt == 0) begin
                    minv = (dcls == 1) ? 'h80 : (dcls == 2) ? 'h800 : 'h10000;
                    acc = int'(dacc);
                    dcls = 0; dacc = 0;
                    if (acc < minv) return ST_OVERLONG;
                    if (acc > 'h10FFFF) return ST_ABOVE_MAX;
                    cp = acc; have = 1;
                end
                return ST_OK;
            end
            ENC_UTF16LE, ENC_UTF16BE:
            begin
                if (dcnt == 0) begin dacc = 21'(b); dcnt = 1; return ST_OK; end
                unit = (e == ENC_UTF16LE) ? (int'(dacc) | (b << 8))
                                          : ((int'(dacc) << 8) | b);
                unit &= 'hFFFF;
                dcnt = 0; dacc = 0;
                if (dcls != 0) begin
                    if (unit < 'hDC00 || unit > 'hDFFF) return ST_BAD_SURR;
                    cp = 'h10000 + (((held_unit & 'h3FF) << 10) | (unit & 'h3FF));
                    dcls = 0; held_unit = 0; have = 1;
                    return ST_OK;
                end
                if (unit >= 'hD800 && unit < 'hDC00) begin
                    held_unit = 16'(unit); dcls = 1; return ST_OK;
                end
                if (unit >= 'hDC00 && unit <= 'hDFFF) return ST_BAD_SURR;
                cp = unit; have = 1;
                return ST_OK;
            end
            ENC_HEX:
            begin
                v = hex_val(b);
                if (dcnt == 0) begin
                    if (b == 'h20 || (b >= 'h09 && b <= 'h0D)) return ST_OK;
                    if (v < 0) return ST_BAD_HEX;
                    dacc = 21'(v); dcnt = 1;
                    return ST_OK;
                end
                if (v < 0) return ST_BAD_HEX;
                cp = ((int'(dacc) << 4) | v) & 'hFF;
                dacc = 0; dcnt = 0; have = 1;
                return ST_OK;
            end
            default:
            begin
                if (b64_done || b <= 'h20) return ST_OK;
                if (b == "=") begin
                    if (dcnt < 2) return ST_BAD_B64;
                    b64_done = 1; dcnt = 0; dacc = 0;
                    return ST_OK;
                end
                v = sextet_val(b);
                if (v < 0) return ST_BAD_B64;
                acc = int'(dacc);
                if (dcnt == 0) begin dacc = 21'(v); dcnt = 1; return ST_OK; end
                if (dcnt == 1) begin
                    cp = ((acc << 2) | (v >> 4)) & 'hFF; dacc = 21'(v & 'hF); dcnt = 2;
                end else if (dcnt == 2) begin
                    cp = ((acc << 4) | (v >> 2)) & 'hFF; dacc = 21'(v & 'h3); dcnt = 3;
                end else begin
                    cp = ((acc << 6) | v) & 'hFF; dacc = 0; dcnt = 0;
                end
                have = 1;
                return ST_OK;
            end
        endcase
    endfunction

    function automatic void quad_out(input int v);
        for (int k = 0; k < 4; k++)
            ob[k] = b64_chars[(v >> (18 - 6 * k)) & 'h3F];
    endfunction

    function automatic logic [3:0] encode_cp(input int cp, output int n);
        logic [2:0] e;
        int w[2];
        int units, a;
        e = norm_enc(dst_enc);
        n = 0;
        if (cp >= 'h110000) return ST_TOO_WIDE;
        case (e)
            ENC_ASCII, ENC_LATIN1:
            begin
                if (cp >= ((e == ENC_ASCII) ? 'h80 : 'h100)) return ST_TOO_WIDE;
                ob[0] = cp[7:0]; n = 1;
            end
            ENC_UTF8:
            begin
                if (cp < 'h80) begin
                    ob[0] = cp[7:0]; n = 1;
                end else if (cp < 'h800) begin
                    ob[0] = 8'(('hC0 | (cp >> 6)));
                    ob[1] = 8'('h80 | (cp & 'h3F)); n = 2;
                end else if (cp < 'h10000) begin
                    ob[0] = 8'('hE0 | (cp >> 12));
                    ob[1] = 8'('h80 | ((cp >> 6) & 'h3F));
                    ob[2] = 8'('h80 | (cp & 'h3F)); n = 3;
                end else begin
                    ob[0] = 8'('hF0 | (cp >> 18));
                    ob[1] = 8'('h80 | ((cp >> 12) & 'h3F));
                    ob[2] = 8'('h80 | ((cp >> 6) & 'h3F));
                    ob[3] = 8'('h80 | (cp & 'h3F)); n = 4;
                end
            end
            ENC_UTF16LE, ENC_UTF16BE:
            begin
                if (cp >= 'hD800 && cp < 'hE000) return ST_TOO_WIDE;
                if (cp < 'h10000) begin
                    w[0] = cp; w[1] = 0; units = 1;
                end else begin
                    a = cp - 'h10000;
                    w[0] = 'hD800 | (a >> 10); w[1] = 'hDC00 | (a & 'h3FF); units = 2;
                end
                for (int k = 0; k < units; k++) begin
                    ob[2*k]   = (e == ENC_UTF16LE) ? w[k][7:0] : w[k][15:8];
                    ob[2*k+1] = (e == ENC_UTF16LE) ? w[k][15:8] : w[k][7:0];
                end
                n = 2 * units;
            end
            ENC_HEX:
            begin
                if (cp >= 'h100) return ST_TOO_WIDE;
                ob[0] = hex_chars[(cp >> 4) & 'hF];
                ob[1] = hex_chars[cp & 'hF]; n = 2;
            end
            default:
            begin
                if (cp >= 'h100) return ST_TOO_WIDE;
                if (ecnt == 2) begin
                    quad_out((int'(eacc) << 8) | cp);
                    eacc = 0; ecnt = 0; n = 4;
                end else begin
                    eacc = (eacc << 8) | 16'(cp);
                    ecnt = ecnt + 1;
                end
            end
        endcase
        return ST_OK;
    endfunction

    function automatic logic [3:0] tail_status();
        logic [2:0] e;
        e = norm_enc(src_enc);
        if (e == ENC_UTF8 && dcnt != 0) return ST_SHORT_U8;
        if (e == ENC_UTF16LE || e == ENC_UTF16BE) begin
            if (dcls != 0) return ST_SHORT_U16;
            if (dcnt != 0) return ST_TRUNC;
        end
        if (e == ENC_HEX && dcnt != 0) return ST_TRUNC;
        if (e == ENC_BASE64 && !b64_done && dcnt != 0) return ST_TRUNC;
        return ST_OK;
    endfunction

    function automatic void transcode_byte(input logic [7:0] b, input logic lst);
        logic [3:0] st;
        int cp, n;
        bit have;
        n = 0;
        if (stream_failed) begin
            if (lst) clear_stream();
            return;
        end
        st = decode_in(int'(b), lst, cp, have);
        if (st == ST_OK && have) st = encode_cp(cp, n);
        if (st == ST_OK && lst) st = tail_status();
        if (st == ST_OK && lst && norm_enc(dst_enc) == ENC_BASE64 && ecnt != 0 && n == 0) begin
            if (ecnt == 1) begin
                quad_out(int'(eacc[7:0]) << 16);
                ob[2] = "=";
            end else begin
                quad_out(int'(eacc) << 8);
            end
            ob[3] = "=";
            n = 4;
        end
        if (st != ST_OK) begin
            expected_xfers.push_back('{8'h00, 1'b0, 1'b1, st});
            if (lst) clear_stream(); else stream_failed = 1'b1;
            return;
        end
        if (lst && n == 0) begin
            expected_xfers.push_back('{8'h00, 1'b0, 1'b1, ST_OK});
            clear_stream();
            return;
        end
        for (int k = 0; k < n; k++)
            expected_xfers.push_back('{ob[k], 1'b1, lst && k == n - 1, ST_OK});
        if (lst) clear_stream();
    endfunction

    task automatic report(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        errors++;
    endtask

    // sender
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            in_byte  <= 8'h00;
            in_last  <= 1'b0;
        end else begin
            if (in_valid && in_ready) transcode_byte(in_byte, in_last);
            if (!in_valid || in_ready) begin
                if (pending_bytes.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    src_item_t it;
                    it = pending_bytes.pop_front();
                    in_valid <= 1'b1;
                    in_byte  <= it.b;
                    in_last  <= it.l;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                if (expected_xfers.size() == 0) begin
                    report($sformatf("unexpected transaction byte=%02h has=%0b last=%0b st=%0d",
                                     out_byte, has_byte, out_last, status));
                end else begin
                    xfer_t x;
                    x = expected_xfers.pop_front();
                    if (out_byte !== x.b || has_byte !== x.h || out_last !== x.l ||
                        status !== x.s)
                        report($sformatf("got byte=%02h has=%0b last=%0b st=%0d, want %02h %0b %0b %0d",
                                         out_byte, has_byte, out_last, status,
                                         x.b, x.h, x.l, x.s));
                end
            end
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) ||
            (pending_bytes.size() == 0 && !in_valid && expected_xfers.size() == 0))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_bytes.size() != 0 || in_valid || expected_xfers.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic set_encodings(input logic [2:0] s, input logic [2:0] d);
        wait_drained();
        cfg_we <= 1'b1; cfg_index <= 1'b0; cfg_data <= s;
        @(posedge clk);
        src_enc = s; clear_stream();
        cfg_index <= 1'b1; cfg_data <= d;
        @(posedge clk);
        dst_enc = d; clear_stream();
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // bytes taken from the top of v, last flag on the final one
    task automatic push_seq(input logic [63:0] v, input int n);
        for (int k = 0; k < n; k++)
            pending_bytes.push_back('{v[8*(n-1-k) +: 8], k == n - 1});
    endtask

    function automatic void flush_stream();
        if (stream_buf.size() == 0) return;
        stream_buf[$].l = 1'b1;
        foreach (stream_buf[k]) pending_bytes.push_back(stream_buf[k]);
        stream_buf.delete();
    endfunction

    function automatic void add(input int b);
        if ($urandom_range(99) < 6)
            stream_buf.push_back('{8'($urandom_range(255)), 1'b0});
        stream_buf.push_back('{8'(b), 1'b0});
    endfunction

    function automatic int rand_cp();
        case ($urandom_range(3))
            0: return $urandom_range('h7F);
            1: return $urandom_range('h7FF, 'h80);
            2: return $urandom_range('hFFFF, 'h800);
            default: return $urandom_range('h10FFFF, 'h10000);
        endcase
    endfunction

    function automatic int hex_digit(input int v);
        int c;
        c = hex_chars[v];
        if (v >= 10 && $urandom_range(1)) c = c + 32;
        return c;
    endfunction

    // one well-formed stream in the current source encoding, with some noise
    function automatic int gen_stream(input int k);
        logic [2:0] e;
        int cp, a, acc, cnt;
        e = norm_enc(src_enc);
        acc = 0;
        cnt = 0;
        for (int i = 0; i < k; i++) begin
            case (e)
                ENC_LATIN1: add($urandom_range(255));
                ENC_ASCII:  add($urandom_range(99) < 90 ? $urandom_range('h7F)
                                                        : $urandom_range(255));
                ENC_UTF8:
                begin
                    cp = rand_cp();
                    if (cp < 'h80) add(cp);
                    else if (cp < 'h800) begin
                        add('hC0 | (cp >> 6)); add('h80 | (cp & 'h3F));
                    end else if (cp < 'h10000) begin
                        add('hE0 | (cp >> 12)); add('h80 | ((cp >> 6) & 'h3F));
                        add('h80 | (cp & 'h3F));
                    end else begin
                        add('hF0 | (cp >> 18)); add('h80 | ((cp >> 12) & 'h3F));
                        add('h80 | ((cp >> 6) & 'h3F)); add('h80 | (cp & 'h3F));
                    end
                end
                ENC_UTF16LE, ENC_UTF16BE:
                begin
                    cp = rand_cp();
                    if (cp >= 'hD800 && cp < 'hE000) cp = cp + 'h800;
                    for (int u = 0; u < (cp >= 'h10000 ? 2 : 1); u++) begin
                        if (cp >= 'h10000) begin
                            a = cp - 'h10000;
                            a = (u == 0) ? ('hD800 | (a >> 10)) : ('hDC00 | (a & 'h3FF));
                        end else begin
                            a = cp;
                        end
                        if (e == ENC_UTF16LE) begin add(a & 'hFF); add(a >> 8); end
                        else begin add(a >> 8); add(a & 'hFF); end
                    end
                end
                ENC_HEX:
                begin
                    a = $urandom_range(255);
                    add(hex_digit(a >> 4)); add(hex_digit(a & 'hF));
                    if ($urandom_range(3) == 0) add($urandom_range(1) ? 'h20 : 'h0A);
                end
                default:
                begin
                    acc = (acc << 8) | $urandom_range(255);
                    cnt++;
                    if (cnt == 3) begin
                        for (int j = 0; j < 4; j++) add(b64_chars[(acc >> (18 - 6*j)) & 'h3F]);
                        if ($urandom_range(4) == 0) add('h0A);
                        acc = 0; cnt = 0;
                    end
                end
            endcase
        end
        if (e == ENC_BASE64 && cnt != 0) begin
            acc = acc << (8 * (3 - cnt));
            for (int j = 0; j <= cnt; j++) add(b64_chars[(acc >> (18 - 6*j)) & 'h3F]);
            if ($urandom_range(5) != 0)
                for (int j = cnt; j < 3; j++) add("=");
        end
        if (stream_buf.size() == 0) add($urandom_range(255));
        a = stream_buf.size();
        flush_stream();
        return a;
    endfunction

    initial
    begin
        logic [2:0] srcs[8];
        logic [2:0] dsts[8];
        int count;
        srcs = '{ENC_UTF8, ENC_UTF16LE, ENC_UTF16BE, ENC_HEX, ENC_BASE64, ENC_LATIN1,
                 ENC_ASCII, 3'd7};
        dsts = '{ENC_UTF16BE, ENC_UTF8, ENC_BASE64, ENC_BASE64, ENC_HEX, ENC_UTF8,
                 ENC_ASCII, ENC_UTF16LE};
        src_enc = ENC_LATIN1;
        dst_enc = ENC_LATIN1;
        clear_stream();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed error and edge streams
        push_seq(64'h00FF, 2);
        set_encodings(ENC_UTF8, ENC_LATIN1);
        push_seq(64'hC080, 2);
        push_seq(64'hF4908080, 4);
        push_seq(64'hE282, 2);
        push_seq(64'hFF41, 2);
        set_encodings(ENC_UTF16LE, ENC_UTF8);
        push_seq(64'h00DC, 2);
        push_seq(64'h00D84100, 4);
        push_seq(64'h00D8, 2);
        set_encodings(ENC_HEX, ENC_BASE64);
        push_seq(64'h343A, 2);
        push_seq(64'h3420, 2);
        push_seq(64'h34, 1);
        push_seq(64'h0A466630, 4);
        set_encodings(ENC_BASE64, ENC_HEX);
        push_seq(64'h3D, 1);
        push_seq(64'h51513D3D7A7A, 6);
        set_encodings(ENC_ASCII, ENC_ASCII);
        push_seq(64'h807F, 2);

        for (int p = 0; p < 8; p++) begin
            set_encodings(srcs[p], dsts[p]);
            send_idle_pct  = (p % 4 == 1) ? 52 : (p % 4 == 3) ? 9 : 0;
            recv_stall_pct = (p % 4 == 2) ? 52 : (p % 4 == 3) ? 9 : 0;
            count = 0;
            while (count < 12) begin
                count += gen_stream($urandom_range(1, 5));
                if (p == 2 && count >= 6 && count < 12) wait_drained();
            end
        end
        set_encodings(3'd7, 3'd7);
        count = gen_stream(4);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        wait_drained();
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

/* text_encoding_transcoder_top.f */
+incdir+sv
sv/tet_pkg.sv
sv/tet_front.sv
sv/tet_back.sv
sv/text_encoding_transcoder_top.sv
verif/text_encoding_transcoder_top_tb.sv
